>>> rtl/core/stc_pkg.sv
// Shared types and constants for the sharded threshold counter.
// No dependencies; used by the channel interfaces, the top level and the checker.
`default_nettype none

package stc_pkg;

  // Field widths of the command and result beats.
  localparam int CMD_W   = 2;
  localparam int SHARD_W = 7;
  localparam int COUNT_W = 32;
  localparam int LOCAL_W = 16;

  typedef logic [CMD_W-1:0]   cmd_t;
  typedef logic [SHARD_W-1:0] shard_t;
  typedef logic [COUNT_W-1:0] count_t;
  typedef logic [LOCAL_W-1:0] local_t;

  // Command codes.
  localparam cmd_t CMD_INC       = 2'd0;
  localparam cmd_t CMD_FLUSH_ONE = 2'd1;
  localparam cmd_t CMD_FLUSH_ALL = 2'd2;
  localparam cmd_t CMD_GET       = 2'd3;

  // Threshold after reset, and the value stored when zero is written.
  localparam local_t DEFAULT_THRESHOLD = 16'd128;

endpackage

`default_nettype wire

>>> rtl/core/stc_in_if.sv
// Command channel: valid/ready handshake carrying a command and a shard index.
// Depends on stc_pkg.
`default_nettype none

interface stc_in_if;
  logic          valid;
  logic          ready;
  stc_pkg::cmd_t   cmd;
  stc_pkg::shard_t shard;

  modport source (output valid, output cmd, output shard, input ready);
  modport sink   (input valid, input cmd, input shard, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stc_out_if.sv
// Result channel: valid/ready handshake carrying one count value per beat.
// Depends on stc_pkg.
`default_nettype none

interface stc_out_if;
  logic          valid;
  logic          ready;
  stc_pkg::count_t count_value;

  modport source (output valid, output count_value, input ready);
  modport sink   (input valid, input count_value, output ready);
endinterface

`default_nettype wire

>>> rtl/core/stc_cfg_if.sv
// Configuration write channel: valid/ready handshake carrying the flush threshold.
// Depends on stc_pkg.
`default_nettype none

interface stc_cfg_if;
  logic          valid;
  logic          ready;
  stc_pkg::local_t thresh;

  modport source (output valid, output thresh, input ready);
  modport sink   (input valid, input thresh, output ready);
endinterface

`default_nettype wire

>>> rtl/core/sharded_threshold_counter_top.sv
// Sharded threshold counter: one command in flight, one shared 32-bit adder.
// Increment reads the shard, adds one, then applies; flush-one reads and clears one
// shard; an out-of-range shard goes straight to the result; flush-all and get walk
// every stored shard, one shard read per cycle. A new command is taken only once the
// result of the last one has been loaded into the output register.
// Synchronous reset clears all counts at once via per-shard valid bits; threshold -> 128.
`default_nettype none

module sharded_threshold_counter_top #(
  parameter int NUM_SHARDS = 128
) (
  input  wire        clk,
  input  wire        rst,
  stc_cfg_if.sink    cfg,
  stc_in_if.sink     req,
  stc_out_if.source  rsp
);

  // Shards past the reach of the shard field are never incremented and stay zero,
  // so only the addressable ones are stored.
  localparam int SHARD_SPAN = 1 << stc_pkg::SHARD_W;
  localparam int DEPTH      = (NUM_SHARDS < SHARD_SPAN) ? NUM_SHARDS : SHARD_SPAN;
  localparam int IDXW       = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_INC    = 3'd1;
  localparam logic [2:0] S_APPLY  = 3'd2;
  localparam logic [2:0] S_FLUSH1 = 3'd3;
  localparam logic [2:0] S_WALK   = 3'd4;
  localparam logic [2:0] S_DONE   = 3'd5;

  logic [2:0]           state;
  stc_pkg::cmd_t        cmd_q;
  logic [IDXW-1:0]      shard_q;
  logic [IDXW-1:0]      walk_idx;
  stc_pkg::count_t      acc;
  stc_pkg::local_t      tmp;
  stc_pkg::count_t      global_count;
  stc_pkg::local_t      thr;
  stc_pkg::local_t      local_mem [DEPTH];
  logic [DEPTH-1:0]     local_vld;
  stc_pkg::local_t      rd_data;
  logic                 rd_vld;
  logic                 out_valid;
  stc_pkg::count_t      out_count;

  logic                 accept;
  logic                 in_ok;
  logic                 walk_last;
  logic [IDXW-1:0]      rd_addr;
  stc_pkg::local_t      rd_val;
  stc_pkg::count_t      add_a;
  stc_pkg::count_t      add_b;
  stc_pkg::count_t      sum;
  logic                 reach;
  logic                 out_load;

  // Handshakes.
  assign cfg.ready       = 1'b1;
  assign req.ready       = (state == S_IDLE);
  assign accept          = req.valid & req.ready;
  assign rsp.valid       = out_valid;
  assign rsp.count_value = out_count;
  assign out_load        = (state == S_DONE) && (!out_valid || rsp.ready);

  assign in_ok     = 32'(req.shard) < 32'(NUM_SHARDS);
  assign walk_last = (walk_idx == IDXW'(DEPTH - 1));
  assign reach     = (tmp >= thr);

  // Read address: the addressed shard at accept, shard zero when a walk starts,
  // else the next shard of a walk.
  always_comb begin
    if (state == S_WALK) begin
      rd_addr = walk_last ? '0 : walk_idx + 1'b1;
    end else if (req.cmd inside {stc_pkg::CMD_FLUSH_ALL, stc_pkg::CMD_GET}) begin
      rd_addr = '0;
    end else begin
      rd_addr = req.shard[IDXW-1:0];
    end
  end

  // An entry whose valid bit is clear reads as zero.
  assign rd_val = rd_vld ? rd_data : '0;

  // Shared adder: local + 1 during an increment, otherwise the accumulator plus a local.
  always_comb begin
    add_a = acc;
    add_b = 32'(rd_val);
    if (state == S_INC) begin
      add_a = 32'(rd_val);
      add_b = 32'd1;
    end else if (state == S_APPLY) begin
      add_b = 32'(tmp);
    end
  end
  assign sum = add_a + add_b;

  // Local-count memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (state == S_APPLY && !reach) begin
      local_mem[shard_q] <= tmp;
    end
    rd_data <= local_mem[rd_addr];
    rd_vld  <= local_vld[rd_addr];
  end

  // Control state, counts, threshold and valid bits.
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      out_valid    <= 1'b0;
      global_count <= '0;
      thr          <= stc_pkg::DEFAULT_THRESHOLD;
      local_vld    <= '0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        thr <= (cfg.thresh == '0) ? stc_pkg::DEFAULT_THRESHOLD : cfg.thresh;
      end
      // The result register fills on a load and empties when its beat is taken.
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (rsp.valid && rsp.ready) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (accept) begin
            unique case (req.cmd) inside
              stc_pkg::CMD_INC:       state <= in_ok ? S_INC : S_DONE;
              stc_pkg::CMD_FLUSH_ONE: state <= in_ok ? S_FLUSH1 : S_DONE;
              stc_pkg::CMD_FLUSH_ALL, stc_pkg::CMD_GET: state <= S_WALK;
              default:                state <= S_DONE;
            endcase
          end
        end
        S_INC: begin
          state <= S_APPLY;
        end
        S_APPLY: begin
          // A full shard empties into the accumulator; otherwise the new count is kept.
          local_vld[shard_q] <= !reach;
          state              <= S_DONE;
        end
        S_FLUSH1: begin
          local_vld[shard_q] <= 1'b0;
          state              <= S_DONE;
        end
        S_WALK: begin
          if (cmd_q == stc_pkg::CMD_FLUSH_ALL) begin
            local_vld[walk_idx] <= 1'b0;
          end
          if (walk_last) begin
            state <= S_DONE;
          end
        end
        S_DONE: begin
          if (out_load) begin
            if (cmd_q != stc_pkg::CMD_GET) begin
              global_count <= acc;
            end
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers: command, shard, accumulator, incremented local, walk index and result.
  always_ff @(posedge clk) begin
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          cmd_q    <= req.cmd;
          shard_q  <= req.shard[IDXW-1:0];
          acc      <= global_count;
          walk_idx <= '0;
        end
      end
      S_INC: begin
        tmp <= sum[stc_pkg::LOCAL_W-1:0];
      end
      S_APPLY: begin
        if (reach) begin
          acc <= sum;
        end
      end
      S_FLUSH1: begin
        acc <= sum;
      end
      S_WALK: begin
        acc <= sum;
        if (!walk_last) begin
          walk_idx <= walk_idx + 1'b1;
        end
      end
      default: begin
      end
    endcase
    if (out_load) begin
      out_count <= acc;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/stc_checker.sv
// Port-level checks for the sharded threshold counter, bound to the top level.
// Depends on stc_pkg and sharded_threshold_counter_top.
`default_nettype none

module stc_checker (
  input wire                    clk,
  input wire                    rst,
  input wire                    req_valid,
  input wire                    req_ready,
  input wire                    rsp_valid,
  input wire                    rsp_ready,
  input wire stc_pkg::count_t   rsp_count
);

  logic [1:0] pend;
  logic       req_beat;
  logic       rsp_beat;

  assign req_beat = req_valid & req_ready;
  assign rsp_beat = rsp_valid & rsp_ready;

  // Commands taken whose result beat has not gone out yet.
  always_ff @(posedge clk) begin
    if (rst) begin
      pend <= '0;
    end else begin
      pend <= pend + {1'b0, req_beat} - {1'b0, rsp_beat};
    end
  end

  // Reset leaves no result pending on the port.
  a_reset_quiet: assert property (@(posedge clk) $past(rst) |-> !rsp_valid)
    else $error("result valid right after reset");

  // The block takes one command at a time.
  a_one_in_work: assert property (@(posedge clk) disable iff (rst)
    req_beat |=> !req_ready)
    else $error("command accepted while another is in work");

  // Every result belongs to an accepted command, and at most two are outstanding.
  a_no_phantom: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (pend != 2'd0) && (pend != 2'd3))
    else $error("result beat without a matching command");

  // A stalled result keeps its value.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_count))
    else $error("stalled result changed or dropped");

endmodule

bind sharded_threshold_counter_top stc_checker u_stc_checker (
  .clk       (clk),
  .rst       (rst),
  .req_valid (req.valid),
  .req_ready (req.ready),
  .rsp_valid (rsp.valid),
  .rsp_ready (rsp.ready),
  .rsp_count (rsp.count_value)
);

`default_nettype wire
